// ===== sv/tdma_slot_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef TDMA_SLOT_SCHEDULER_DEFINES_SVH
`define TDMA_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdma scheduler check failed");

// Next-cycle implication, checked out of reset.
`define TSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdma scheduler check failed");

`endif

// ===== sv/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

  localparam int MAX_PEERS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  localparam int ADDR_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int IN_TIME_W  = 48;
  localparam int SLOT_W     = 4;
  localparam int PEERS_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_START   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_STARTED = 2'd1,
    ST_TABLE_FULL  = 2'd2
  } status_t;

endpackage

// ===== sv/tdma_slot_scheduler.sv =====
`timescale 1ns / 1ps
// TDMA slot scheduler.
// Input items arrive as commands: start is sampled when busy is low, with
// in_command, in_now_ms and in_peer_address. Commands are receive, poll and
// start. Exactly one result item follows each accepted item, shown for one
// cycle with out_valid high; the receiver cannot stall, so results are never
// held back. busy stays high from acceptance until the result cycle ends.
// Start, unused commands, events before start and polls that do not fire go
// straight to the result. Receives and firing polls walk the peer table, held
// in a memory with one write port and one registered read port, with a read
// state and an evaluate state per entry: one expiry pass, one search pass, an
// insertion shift of up to N entries and a final rank pass, for N live peers.
// A receive that finds its sender adds a multiply and a restoring divide of one
// quotient bit per cycle. One item is in work at a time. Configuration is
// written through cfg_we, cfg_index and cfg_wdata; the user must write it only
// while idle, which the block itself does not enforce. Reset clears the peer
// count, ranks, times and the started flag; the table memory needs no clearing
// since only entries below the peer count are read.
`include "tdma_slot_scheduler_defines.svh"

module tdma_slot_scheduler #(
  parameter int MAX_PEERS = tss_pkg::MAX_PEERS_DEF,
  parameter int TIME_BITS = tss_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tss_pkg::CMD_W-1:0]       in_command,
  input  logic [tss_pkg::IN_TIME_W-1:0]   in_now_ms,
  input  logic [tss_pkg::ADDR_W-1:0]      in_peer_address,
  output logic                            out_valid,
  output logic                            out_send_now,
  output logic [tss_pkg::IN_TIME_W-1:0]   out_next_transmit_ms,
  output logic [tss_pkg::SLOT_W-1:0]      out_own_slot,
  output logic [tss_pkg::SLOT_W-1:0]      out_sender_slot,
  output logic [tss_pkg::PEERS_W-1:0]     out_live_peers,
  output logic [tss_pkg::STATUS_W-1:0]    out_status,
  input  logic                            cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IW    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW    = $clog2(MAX_PEERS + 1);
  localparam int DW    = CW + 1;
  localparam int PW    = tss_pkg::PERIOD_W + DW;
  localparam int DCW   = $clog2(PW + 1);
  localparam int AW    = tss_pkg::ADDR_W;
  localparam int ENT_W = AW + TIME_BITS;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_CRD  = 15'h0002,
    S_CEV  = 15'h0004,
    S_FRD  = 15'h0008,
    S_FEV  = 15'h0010,
    S_UPD  = 15'h0020,
    S_SRD  = 15'h0040,
    S_SEV  = 15'h0080,
    S_INS  = 15'h0100,
    S_ORD  = 15'h0200,
    S_OEV  = 15'h0400,
    S_FIN  = 15'h0800,
    S_MUL  = 15'h1000,
    S_DIV  = 15'h2000,
    S_DONE = 15'h4000
  } state_t;

  typedef struct packed {
    logic [AW-1:0]        addr;
    logic [TIME_BITS-1:0] seen;
  } entry_t;

  state_t state_r;

  logic [AW-1:0]                      own_addr_r;
  logic [tss_pkg::PERIOD_W-1:0]       period_r;
  logic [CW-1:0]                      count_r;
  logic [IW-1:0]                      own_rank_r;
  logic [IW-1:0]                      sender_rank_r;
  logic [TIME_BITS-1:0]               next_r;
  logic [TIME_BITS-1:0]               last_rx_r;
  logic                               started_r;

  tss_pkg::cmd_t                      cmd_r;
  logic [TIME_BITS-1:0]               now_r;
  logic [AW-1:0]                      key_r;
  logic [CW-1:0]                      idx_r;
  logic [CW-1:0]                      k_r;
  logic [CW-1:0]                      pos_r;
  logic                               found_r;
  logic [IW-1:0]                      fpos_r;
  logic                               ofound_r;
  logic [IW-1:0]                      opos_r;
  logic                               kfound_r;
  logic [IW-1:0]                      kpos_r;
  logic [DW-1:0]                      delta_r;
  logic [PW-1:0]                      quo_r;
  logic [CW-1:0]                      rem_r;
  logic [DCW-1:0]                     dcnt_r;
  logic                               send_r;
  tss_pkg::status_t                   status_r;

  entry_t                             mem [MAX_PEERS];
  entry_t                             rd_r;

  logic                               mem_we;
  logic [IW-1:0]                      mem_waddr;
  entry_t                             mem_wdata;
  logic [IW-1:0]                      mem_raddr;

  logic [TIME_BITS-1:0]               now_in;
  logic [TIME_BITS-1:0]               age;
  logic [TIME_BITS-1:0]               limit;
  logic [CW-1:0]                      pos_m1;
  logic [IW-1:0]                      own_rank_new;
  logic [CW:0]                        div_trial;
  logic                               div_ge;

  assign now_in  = TIME_BITS'(in_now_ms);
  assign age     = now_r - rd_r.seen;
  assign limit   = TIME_BITS'({period_r, 1'b0});
  assign pos_m1  = pos_r - CW'(1);
  assign own_rank_new = ofound_r ? opos_r : own_rank_r;
  assign div_trial = {rem_r, quo_r[PW-1]};
  assign div_ge    = div_trial >= {1'b0, count_r};

  // Table memory: one write and one registered read per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r[IW-1:0];
    mem_wdata = rd_r;
    mem_raddr = idx_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_we    = start && (in_command == tss_pkg::CMD_START);
        mem_waddr = '0;
        mem_wdata = '{addr: own_addr_r, seen: now_in};
      end
      S_CEV: begin
        mem_we = (age <= limit);
      end
      S_UPD: begin
        mem_we    = found_r;
        mem_waddr = fpos_r;
        mem_wdata = '{addr: key_r, seen: now_r};
      end
      S_SRD: begin
        mem_raddr = pos_m1[IW-1:0];
      end
      S_SEV: begin
        mem_we    = rd_r.addr > key_r;
        mem_waddr = pos_r[IW-1:0];
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IW-1:0];
        mem_wdata = '{addr: key_r, seen: now_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
      period_r   <= tss_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tss_pkg::REG_OWN_ADDRESS) begin
        own_addr_r <= cfg_wdata[AW-1:0];
      end else if (cfg_index == tss_pkg::REG_PERIOD_MS) begin
        period_r <= cfg_wdata[tss_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      own_rank_r    <= '0;
      sender_rank_r <= '0;
      next_r        <= '0;
      last_rx_r     <= '0;
      started_r     <= 1'b0;
      send_r        <= 1'b0;
      status_r      <= tss_pkg::ST_OK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= tss_pkg::cmd_t'(in_command);
            now_r    <= now_in;
            idx_r    <= '0;
            k_r      <= '0;
            send_r   <= 1'b0;
            status_r <= tss_pkg::ST_OK;
            state_r  <= S_DONE;
            if (in_command == tss_pkg::CMD_START) begin
              count_r    <= CW'(1);
              own_rank_r <= '0;
              next_r     <= now_in;
              last_rx_r  <= now_in;
              started_r  <= 1'b1;
            end else if (in_command == tss_pkg::CMD_UNUSED) begin
              status_r <= started_r ? tss_pkg::ST_OK : tss_pkg::ST_NOT_STARTED;
            end else if (!started_r) begin
              status_r <= tss_pkg::ST_NOT_STARTED;
            end else if (in_command == tss_pkg::CMD_RECEIVE) begin
              key_r     <= in_peer_address;
              last_rx_r <= now_in;
              state_r   <= S_CRD;
            end else if (now_in > next_r) begin
              key_r   <= own_addr_r;
              next_r  <= next_r + TIME_BITS'(period_r);
              send_r  <= 1'b1;
              state_r <= S_CRD;
            end
          end
        end
        S_CRD: begin
          if (idx_r == count_r) begin
            count_r <= k_r;
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_FRD;
          end else begin
            state_r <= S_CEV;
          end
        end
        S_CEV: begin
          if (age <= limit) begin
            k_r <= k_r + CW'(1);
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= S_CRD;
        end
        S_FRD: begin
          state_r <= (idx_r == count_r) ? S_UPD : S_FEV;
        end
        S_FEV: begin
          if (!found_r && rd_r.addr == key_r) begin
            found_r <= 1'b1;
            fpos_r  <= idx_r[IW-1:0];
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= S_FRD;
        end
        S_UPD: begin
          idx_r    <= '0;
          ofound_r <= 1'b0;
          kfound_r <= 1'b0;
          if (found_r) begin
            state_r <= S_ORD;
          end else if (count_r == CW'(MAX_PEERS)) begin
            status_r <= tss_pkg::ST_TABLE_FULL;
            state_r  <= S_ORD;
          end else begin
            pos_r   <= count_r;
            state_r <= S_SRD;
          end
        end
        S_SRD: begin
          state_r <= (pos_r == '0) ? S_INS : S_SEV;
        end
        S_SEV: begin
          // Entries above the new address move up by one place.
          if (rd_r.addr > key_r) begin
            pos_r   <= pos_m1;
            state_r <= S_SRD;
          end else begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          count_r <= count_r + CW'(1);
          state_r <= S_ORD;
        end
        S_ORD: begin
          state_r <= (idx_r == count_r) ? S_FIN : S_OEV;
        end
        S_OEV: begin
          if (!ofound_r && rd_r.addr == own_addr_r) begin
            ofound_r <= 1'b1;
            opos_r   <= idx_r[IW-1:0];
          end
          if (!kfound_r && rd_r.addr == key_r) begin
            kfound_r <= 1'b1;
            kpos_r   <= idx_r[IW-1:0];
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= S_ORD;
        end
        S_FIN: begin
          own_rank_r <= own_rank_new;
          state_r    <= S_DONE;
          if (cmd_r == tss_pkg::CMD_RECEIVE && kfound_r) begin
            sender_rank_r <= kpos_r;
            if (own_rank_new > kpos_r) begin
              delta_r <= DW'(own_rank_new) - DW'(kpos_r);
            end else begin
              delta_r <= DW'(own_rank_new) + DW'(count_r) - DW'(kpos_r);
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          quo_r   <= PW'(period_r) * PW'(delta_r);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_r == DCW'(PW)) begin
            next_r  <= last_rx_r + TIME_BITS'(quo_r);
            state_r <= S_DONE;
          end else begin
            rem_r  <= div_ge ? CW'(div_trial - {1'b0, count_r}) : CW'(div_trial);
            quo_r  <= {quo_r[PW-2:0], div_ge};
            dcnt_r <= dcnt_r + DCW'(1);
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_DONE);
  assign out_send_now         = send_r;
  assign out_next_transmit_ms = tss_pkg::IN_TIME_W'(next_r);
  assign out_own_slot         = tss_pkg::SLOT_W'(own_rank_r);
  assign out_sender_slot      = tss_pkg::SLOT_W'(sender_rank_r);
  assign out_live_peers       = tss_pkg::PEERS_W'(count_r);
  assign out_status           = status_r;

  `TSS_ASSERT_NEXT(a_result_ends_item, out_valid, !busy)
  `TSS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `TSS_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= CW'(MAX_PEERS))
  `TSS_ASSERT_NOW(a_send_only_ok, out_valid && out_send_now,
                  out_status != tss_pkg::ST_NOT_STARTED)

endmodule

// ===== test/tdma_checker.sv =====
`timescale 1ns / 1ps

module tdma_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [tss_pkg::CMD_W-1:0]      in_command,
  input  logic [tss_pkg::IN_TIME_W-1:0]  in_now_ms,
  input  logic [tss_pkg::ADDR_W-1:0]     in_peer_address,
  input  logic                           out_valid,
  input  logic                           out_send_now,
  input  logic [tss_pkg::IN_TIME_W-1:0]  out_next_transmit_ms,
  input  logic [tss_pkg::SLOT_W-1:0]     out_own_slot,
  input  logic [tss_pkg::SLOT_W-1:0]     out_sender_slot,
  input  logic [tss_pkg::PEERS_W-1:0]    out_live_peers,
  input  logic [tss_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             errors,
  output int                             pending
);
  import tss_pkg::*;

  localparam int PEERS = 16;

  typedef struct packed {
    logic        send_now;
    logic [47:0] next_tx;
    logic [3:0]  own_slot;
    logic [3:0]  sender_slot;
    logic [4:0]  live;
    status_t     status;
  } sched_result_t;

  sched_result_t schedule_q[$];

  logic [31:0] my_addr;
  logic [15:0] period;
  logic [31:0] tbl_addr [PEERS];
  logic [47:0] tbl_seen [PEERS];
  int          npeers;
  logic [3:0]  my_rank;
  logic [3:0]  tx_rank;
  logic [47:0] next_tx;
  logic [47:0] last_rx;
  logic        running;

  function automatic int rank_of(input logic [31:0] a);
    for (int i = 0; i < npeers; i++)
      if (tbl_addr[i] == a) return i;
    return -1;
  endfunction

  // Expire stale peers, then refresh or insert the address; true when dropped.
  function automatic bit age_and_insert(input logic [31:0] a, input logic [47:0] t);
    int k;
    int pos;
    logic [47:0] age;
    bit dropped;
    k = 0;
    dropped = 0;
    for (int i = 0; i < npeers; i++) begin
      age = t - tbl_seen[i];
      if (age <= 48'(2 * int'(period))) begin
        tbl_addr[k] = tbl_addr[i];
        tbl_seen[k] = tbl_seen[i];
        k++;
      end
    end
    npeers = k;
    pos = rank_of(a);
    if (pos >= 0) begin
      tbl_seen[pos] = t;
    end else if (npeers >= PEERS) begin
      dropped = 1;
    end else begin
      pos = npeers;
      while (pos > 0 && tbl_addr[pos-1] > a) begin
        tbl_addr[pos] = tbl_addr[pos-1];
        tbl_seen[pos] = tbl_seen[pos-1];
        pos--;
      end
      tbl_addr[pos] = a;
      tbl_seen[pos] = t;
      npeers++;
    end
    pos = rank_of(my_addr);
    if (pos >= 0) my_rank = pos[3:0];
    return dropped;
  endfunction

  function automatic sched_result_t predict_event(input cmd_t c, input logic [47:0] t,
                                                  input logic [31:0] a);
    sched_result_t r;
    int rk;
    longint unsigned delta;
    r.send_now = 0;
    r.status = ST_OK;
    if (c == CMD_START) begin
      tbl_addr[0] = my_addr;
      tbl_seen[0] = t;
      npeers = 1;
      my_rank = 0;
      next_tx = t;
      last_rx = t;
      running = 1;
    end else if (c == CMD_UNUSED) begin
      r.status = running ? ST_OK : ST_NOT_STARTED;
    end else if (!running) begin
      r.status = ST_NOT_STARTED;
    end else if (c == CMD_RECEIVE) begin
      if (age_and_insert(a, t)) r.status = ST_TABLE_FULL;
      last_rx = t;
      rk = rank_of(a);
      if (rk >= 0 && npeers > 0) begin
        tx_rank = rk[3:0];
        if (my_rank > tx_rank) delta = my_rank - tx_rank;
        else delta = longint'(my_rank) + npeers - tx_rank;
        next_tx = last_rx + 48'((longint'(period) * delta) / npeers);
      end
    end else if (t > next_tx) begin
      if (age_and_insert(my_addr, t)) r.status = ST_TABLE_FULL;
      next_tx = next_tx + 48'(period);
      r.send_now = 1;
    end
    r.next_tx = next_tx;
    r.own_slot = my_rank;
    r.sender_slot = tx_rank;
    r.live = npeers[4:0];
    return r;
  endfunction

  assign pending = schedule_q.size();

  always @(posedge clk) begin
    sched_result_t exp_r;
    int fails;
    if (!rst_n) begin
      my_addr <= 0;
      period <= PERIOD_RESET;
      npeers = 0;
      my_rank = 0;
      tx_rank = 0;
      next_tx = 0;
      last_rx = 0;
      running = 0;
      schedule_q.delete();
      errors <= 0;
    end else begin
      fails = 0;
      if (cfg_we) begin
        if (cfg_index == REG_OWN_ADDRESS) my_addr <= cfg_wdata;
        else if (cfg_index == REG_PERIOD_MS) period <= cfg_wdata[15:0];
      end
      if (out_valid) begin
        if (schedule_q.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          exp_r = schedule_q.pop_front();
          if (out_send_now !== exp_r.send_now) begin
            $error("send_now expected %0d got %0d", exp_r.send_now, out_send_now);
            fails++;
          end
          if (out_next_transmit_ms !== exp_r.next_tx) begin
            $error("next_transmit_ms expected %0d got %0d", exp_r.next_tx,
                   out_next_transmit_ms);
            fails++;
          end
          if (out_own_slot !== exp_r.own_slot) begin
            $error("own_slot expected %0d got %0d", exp_r.own_slot, out_own_slot);
            fails++;
          end
          if (out_sender_slot !== exp_r.sender_slot) begin
            $error("sender_slot expected %0d got %0d", exp_r.sender_slot, out_sender_slot);
            fails++;
          end
          if (out_live_peers !== exp_r.live) begin
            $error("live_peers expected %0d got %0d", exp_r.live, out_live_peers);
            fails++;
          end
          if (out_status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_status);
            fails++;
          end
        end
      end
      errors <= errors + fails;
      // Prediction after the compare, so a same-edge result sees the older item.
      if (start && !busy)
        schedule_q.insert(schedule_q.size(),
                          predict_event(cmd_t'(in_command), in_now_ms, in_peer_address));
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tss_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_command = CMD_UNUSED;
  logic [47:0] in_now_ms = 0;
  logic [31:0] in_peer_address = 0;
  logic        out_valid;
  logic        out_send_now;
  logic [47:0] out_next_transmit_ms;
  logic [3:0]  out_own_slot;
  logic [3:0]  out_sender_slot;
  logic [4:0]  out_live_peers;
  logic [1:0]  out_status;
  logic        cfg_we = 0;
  logic [0:0]  cfg_index = REG_OWN_ADDRESS;
  logic [31:0] cfg_wdata = 0;
  int          errors;
  int          pending;
  int          cycles = 0;

  int          gap_pct;
  logic [31:0] node_addr;
  logic [15:0] node_period;
  logic [47:0] clock_ms;
  logic [31:0] addr_pool [24];

  always #10 clk = ~clk;

  tdma_slot_scheduler dut (.*);
  tdma_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(input cmd_t c, input logic [47:0] t, input logic [31:0] a);
    // The sender holds off for each cycle with probability gap_pct percent.
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_command <= c;
    in_now_ms <= t;
    in_peer_address <= a;
    do @(posedge clk); while (busy);
  endtask

  // Waits for every result, then writes both registers with the block idle.
  task automatic set_config(input logic [31:0] a, input logic [15:0] p);
    start <= 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
    node_addr = a;
    node_period = p;
    cfg_we <= 1;
    cfg_index <= REG_OWN_ADDRESS;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= REG_PERIOD_MS;
    cfg_wdata <= {16'd0, p};
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int r;
    int step;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 0;
    addr_pool[1] = 32'hFFFF_FFFF;
    addr_pool[2] = node_addr;
    issue(CMD_START, clock_ms, $urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      step = $urandom_range(0, 99);
      if (step < 70) clock_ms += $urandom_range(0, node_period / 16 + 1);
      else if (step < 95) clock_ms += $urandom_range(0, node_period / 2 + 1);
      else clock_ms += 3 * node_period;
      if (r < 3) begin
        issue(CMD_START, clock_ms, $urandom);
      end else if (r < 6) begin
        issue(CMD_UNUSED, clock_ms, $urandom);
      end else if (r < 9) begin
        // Noise: a jump anywhere in time, which also ages out the table.
        clock_ms = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
        issue(cmd_t'($urandom_range(0, 1)), clock_ms, $urandom);
      end else if (r < 45) begin
        issue(CMD_POLL, clock_ms, $urandom);
      end else begin
        issue(CMD_RECEIVE, clock_ms, addr_pool[$urandom_range(0, 23)]);
      end
    end
  endtask

  initial begin
    gap_pct = 6;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Events before start must be rejected.
    issue(CMD_RECEIVE, 48'd5, 32'h1234_5678);
    issue(CMD_POLL, 48'hFFFF_FFFF_FFFF, 32'h0);
    issue(CMD_UNUSED, 48'd0, 32'hFFFF_FFFF);
    set_config(32'h8000_0000, 16'd100);
    issue(CMD_START, 48'd0, 32'h0);
    issue(CMD_UNUSED, 48'd1, 32'h0);
    issue(CMD_POLL, 48'd0, 32'h0);
    issue(CMD_POLL, 48'd1, 32'h0);
    issue(CMD_RECEIVE, 48'd10, 32'h0);
    issue(CMD_RECEIVE, 48'd12, 32'hFFFF_FFFF);
    issue(CMD_RECEIVE, 48'd14, 32'h8000_0000);
    // Fill the table past its size so that the last new peers are dropped.
    for (int i = 0; i < 15; i++)
      issue(CMD_RECEIVE, 48'd20, 32'h1000_0000 + i * 32'h0100_0001);
    // Own entry ages out; own slot must keep its last value.
    issue(CMD_RECEIVE, 48'd400, 32'h0000_0007);
    issue(CMD_POLL, 48'd401, 32'h0);
    // Time wrap around the top of the counter.
    issue(CMD_START, 48'hFFFF_FFFF_FFFE, 32'h0);
    issue(CMD_RECEIVE, 48'd3, 32'h0000_0001);
    issue(CMD_POLL, 48'hFFFF_FFFF_FFFF, 32'h0);

    clock_ms = 0;
    set_config(32'h0, 16'd1);
    random_phase(420);
    gap_pct = 62;
    set_config(32'hFFFF_FFFF, 16'd65535);
    clock_ms = 48'hFFFF_FFF0_0000;
    random_phase(420);
    gap_pct = 0;
    set_config($urandom, 16'($urandom_range(1, 65535)));
    random_phase(420);
    set_config($urandom, 16'($urandom_range(2, 400)));
    random_phase(420);

    start <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
